/* rtl/adcscan_pkg.sv */
// Package for the ADC scan / oversampling / limit check block.
// Shared constants, register codes, payload types and the scan sensor table.
// No dependencies.
`default_nettype none

package adcscan_pkg;

   localparam int ROUNDS_PER_WINDOW = 16;
   localparam int SAMPLE_BITS       = 10;

   localparam int HEATERS   = 4;
   localparam int PHASES    = 10;
   localparam int ADC_W     = 10;
   localparam int SUM_W     = 14;
   localparam int PSUM_W    = 13;
   localparam int SENSOR_W  = 3;
   localparam int PHASE_W   = 4;
   localparam int SLOT_W    = PHASE_W - 1;
   localparam int CSR_IDX_W = 4;
   localparam int ROUND_W   = (ROUNDS_PER_WINDOW > 1) ? $clog2(ROUNDS_PER_WINDOW) : 1;

   localparam logic [SUM_W-1:0]  HEATER_MAX   = '1;
   localparam logic [PSUM_W-1:0] PRESSURE_MAX = '1;
   localparam logic [SUM_W-1:0]  OVER_RESET   = SUM_W'(16368);
   localparam logic [SUM_W-1:0]  UNDER_RESET  = '0;
   localparam logic [ADC_W-1:0]  SAMPLE_MASK  = ADC_W'((64'd1 << SAMPLE_BITS) - 64'd1);

   localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(PHASES - 1);
   localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS_PER_WINDOW - 1);

   // sensor codes
   localparam logic [SENSOR_W-1:0] SENSOR_HEATER_0 = 3'd0;
   localparam logic [SENSOR_W-1:0] SENSOR_HEATER_1 = 3'd1;
   localparam logic [SENSOR_W-1:0] SENSOR_HEATER_2 = 3'd2;
   localparam logic [SENSOR_W-1:0] SENSOR_HEATER_3 = 3'd3;
   localparam logic [SENSOR_W-1:0] SENSOR_PRESSURE = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OVER_LIMIT_0  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVER_LIMIT_1  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVER_LIMIT_2  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OVER_LIMIT_3  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER_LIMIT_0 = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER_LIMIT_1 = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER_LIMIT_2 = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER_LIMIT_3 = 4'd7;

   typedef logic [HEATERS-1:0][SUM_W-1:0] limit_array_type;

   typedef struct packed {
      logic [ADC_W-1:0] adc_value;
      logic             values_taken;
      logic             settling;
   } req_type;

   typedef struct packed {
      logic                start_conversion;
      logic [SENSOR_W-1:0] conversion_sensor;
      logic                window_done;
      logic                sums_ready;
      limit_array_type     heater_sum;
      logic [PSUM_W-1:0]   pressure_sum;
      logic [HEATERS-1:0]  over_mask;
      logic [HEATERS-1:0]  under_mask;
   } rsp_type;

   // scan order: heater 0, 3, 1, 2, then pressure
   function automatic logic [SENSOR_W-1:0] sensor_of_slot(input logic [SLOT_W-1:0] slot);
      logic [SENSOR_W-1:0] sensor;
      unique case (slot)
         3'd0:    sensor = SENSOR_HEATER_0;
         3'd1:    sensor = SENSOR_HEATER_3;
         3'd2:    sensor = SENSOR_HEATER_1;
         3'd3:    sensor = SENSOR_HEATER_2;
         3'd4:    sensor = SENSOR_PRESSURE;
         default: sensor = SENSOR_HEATER_0;
      endcase
      return sensor;
   endfunction

endpackage

`default_nettype wire

/* rtl/adcscan_limit_check.sv */
// Over / under limit comparators, one pair per heater, with polarity select.
// Depends on adcscan_pkg.
`default_nettype none

module adcscan_limit_check (
   input  wire adcscan_pkg::limit_array_type        sums,
   input  wire adcscan_pkg::limit_array_type        over_limit,
   input  wire adcscan_pkg::limit_array_type        under_limit,
   input  wire logic                                check_en,
   output logic [adcscan_pkg::HEATERS-1:0]          over_mask,
   output logic [adcscan_pkg::HEATERS-1:0]          under_mask
);
   import adcscan_pkg::*;

   always_comb begin
      logic inverted;
      for (int e = 0; e < HEATERS; e++) begin
         // under above over means the sensor reads backwards
         inverted = under_limit[e] > over_limit[e];
         if (inverted) begin
            over_mask[e]  = check_en && (sums[e] <= over_limit[e]);
            under_mask[e] = check_en && (sums[e] >= under_limit[e]);
         end else begin
            over_mask[e]  = check_en && (sums[e] >= over_limit[e]);
            under_mask[e] = check_en && (sums[e] <= under_limit[e]);
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/adcscan_scan_core.sv */
// Scan sequencer, oversampling accumulators, latched sums and ready flag.
// Depends on adcscan_pkg and adcscan_limit_check.
`default_nettype none

module adcscan_scan_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire adcscan_pkg::req_type          item,
   input  wire adcscan_pkg::limit_array_type  over_limit,
   input  wire adcscan_pkg::limit_array_type  under_limit,
   output adcscan_pkg::rsp_type               result
);
   import adcscan_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   limit_array_type    hacc_ff, hacc_in, hacc_add;
   logic [PSUM_W-1:0]  pacc_ff, pacc_in, pacc_add;
   limit_array_type    hlat_ff, hlat_in;
   logic [PSUM_W-1:0]  plat_ff, plat_in;
   logic               ready_ff, ready_in;

   logic [PHASE_W-1:0]  phase;
   logic [SENSOR_W-1:0] sensor;
   logic                prepare;
   logic                last_phase;
   logic                done;
   logic                ready_mid;
   logic [ADC_W-1:0]    sample;
   logic [SUM_W:0]      hsum;
   logic [PSUM_W:0]     psum;
   logic [HEATERS-1:0]  over_mask;
   logic [HEATERS-1:0]  under_mask;

   always_comb begin
      phase      = (phase_ff < PHASE_W'(PHASES)) ? phase_ff : '0;
      sensor     = sensor_of_slot(phase[PHASE_W-1:1]);
      prepare    = ~phase[0];
      sample     = item.adc_value & SAMPLE_MASK;
      last_phase = (phase == LAST_PHASE);
      done       = last_phase && (round_ff == LAST_ROUND);

      hsum = {1'b0, hacc_ff[sensor[1:0]]} + (SUM_W+1)'(sample);
      psum = {1'b0, pacc_ff} + (PSUM_W+1)'(sample >> 1);

      hacc_add = hacc_ff;
      pacc_add = pacc_ff;
      if (!prepare) begin
         if (sensor == SENSOR_PRESSURE) begin
            pacc_add = psum[PSUM_W] ? PRESSURE_MAX : psum[PSUM_W-1:0];
         end else begin
            hacc_add[sensor[1:0]] = hsum[SUM_W] ? HEATER_MAX : hsum[SUM_W-1:0];
         end
      end

      phase_in = last_phase ? '0 : phase + PHASE_W'(1);
      if (!last_phase) begin
         round_in = round_ff;
      end else if (done) begin
         round_in = '0;
      end else begin
         round_in = round_ff + ROUND_W'(1);
      end

      // a take on the same tick is seen before the window closes
      ready_mid = item.values_taken ? 1'b0 : ready_ff;
      hlat_in   = hlat_ff;
      plat_in   = plat_ff;
      hacc_in   = hacc_add;
      pacc_in   = pacc_add;
      ready_in  = ready_mid;
      if (done) begin
         if (!ready_mid) begin
            hlat_in = hacc_add;
            plat_in = pacc_add;
         end
         hacc_in  = '0;
         pacc_in  = '0;
         ready_in = 1'b1;
      end
   end

   adcscan_limit_check u_limit_check (
      .sums        (hlat_in),
      .over_limit  (over_limit),
      .under_limit (under_limit),
      .check_en    (done && !item.settling),
      .over_mask   (over_mask),
      .under_mask  (under_mask)
   );

   always_comb begin
      result.start_conversion  = prepare;
      result.conversion_sensor = sensor;
      result.window_done       = done;
      result.sums_ready        = ready_in;
      result.heater_sum        = hlat_in;
      result.pressure_sum      = plat_in;
      result.over_mask         = over_mask;
      result.under_mask        = under_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         round_ff <= '0;
         hacc_ff  <= '0;
         pacc_ff  <= '0;
         hlat_ff  <= '0;
         plat_ff  <= '0;
         ready_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         round_ff <= round_in;
         hacc_ff  <= hacc_in;
         pacc_ff  <= pacc_in;
         hlat_ff  <= hlat_in;
         plat_ff  <= plat_in;
         ready_ff <= ready_in;
      end
   end

   phase_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff < PHASE_W'(PHASES))
      else $error("scan phase left the ten-phase range");

   window_closes_on_pressure: assert property (@(posedge clock) disable iff (reset)
      step && done |-> !prepare && sensor == SENSOR_PRESSURE)
      else $error("window closed outside the pressure measure phase");

   close_clears_accumulators: assert property (@(posedge clock) disable iff (reset)
      step && done |=> hacc_ff == '0 && pacc_ff == '0 && round_ff == '0 && ready_ff)
      else $error("window close left accumulators or round count set");

endmodule

`default_nettype wire

/* rtl/adc_scan_oversample_limit_check.sv */
// Path: req transfer into the input register, then the result register, which drives rsp_valid.
// Throughput: one item per cycle while the result side is not stalled; one scan tick of adds
// and compares sits between the input register and the result register.
// Reset (synchronous, active high) clears scan phase, round count, accumulators,
// latched sums and the ready flag, and loads the default over/under limits.
// Depends on adcscan_pkg and adcscan_scan_core.
`default_nettype none

module adc_scan_oversample_limit_check (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [adcscan_pkg::ADC_W-1:0]          req_adc_value,
   input  wire logic                                   req_values_taken,
   input  wire logic                                   req_settling,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic                                        rsp_start_conversion,
   output logic [adcscan_pkg::SENSOR_W-1:0]            rsp_conversion_sensor,
   output logic                                        rsp_window_done,
   output logic                                        rsp_sums_ready,
   output logic [adcscan_pkg::SUM_W-1:0]               rsp_heater_sum_0,
   output logic [adcscan_pkg::SUM_W-1:0]               rsp_heater_sum_1,
   output logic [adcscan_pkg::SUM_W-1:0]               rsp_heater_sum_2,
   output logic [adcscan_pkg::SUM_W-1:0]               rsp_heater_sum_3,
   output logic [adcscan_pkg::PSUM_W-1:0]              rsp_pressure_sum,
   output logic [adcscan_pkg::HEATERS-1:0]             rsp_over_mask,
   output logic [adcscan_pkg::HEATERS-1:0]             rsp_under_mask,
   input  wire logic                                   csr_wr_en,
   input  wire logic [adcscan_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [adcscan_pkg::SUM_W-1:0]          csr_wdata
);
   import adcscan_pkg::*;

   limit_array_type over_ff, over_in;
   limit_array_type under_ff, under_in;

   req_type req_ff, req_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic    req_xfer;
   logic    advance;
   rsp_type core_rsp;

   always_comb begin
      over_in  = over_ff;
      under_in = under_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OVER_LIMIT_0:  over_in[0]  = csr_wdata;
            CSR_OVER_LIMIT_1:  over_in[1]  = csr_wdata;
            CSR_OVER_LIMIT_2:  over_in[2]  = csr_wdata;
            CSR_OVER_LIMIT_3:  over_in[3]  = csr_wdata;
            CSR_UNDER_LIMIT_0: under_in[0] = csr_wdata;
            CSR_UNDER_LIMIT_1: under_in[1] = csr_wdata;
            CSR_UNDER_LIMIT_2: under_in[2] = csr_wdata;
            CSR_UNDER_LIMIT_3: under_in[3] = csr_wdata;
            default: ; // unmapped index, dropped
         endcase
      end
   end

   // the scan steps when the input register can move into the result register
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      req_in.adc_value    = req_adc_value;
      req_in.values_taken = req_values_taken;
      req_in.settling     = req_settling;
      in_valid_in  = req_xfer || (in_valid_ff && !advance);
      rsp_in       = core_rsp;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   adcscan_scan_core u_scan_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (req_ff),
      .over_limit  (over_ff),
      .under_limit (under_ff),
      .result      (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < HEATERS; e++) begin
            over_ff[e]  <= OVER_RESET;
            under_ff[e] <= UNDER_RESET;
         end
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         over_ff      <= over_in;
         under_ff     <= under_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_start_conversion  = rsp_ff.start_conversion;
   assign rsp_conversion_sensor = rsp_ff.conversion_sensor;
   assign rsp_window_done       = rsp_ff.window_done;
   assign rsp_sums_ready        = rsp_ff.sums_ready;
   assign rsp_heater_sum_0      = rsp_ff.heater_sum[0];
   assign rsp_heater_sum_1      = rsp_ff.heater_sum[1];
   assign rsp_heater_sum_2      = rsp_ff.heater_sum[2];
   assign rsp_heater_sum_3      = rsp_ff.heater_sum[3];
   assign rsp_pressure_sum      = rsp_ff.pressure_sum;
   assign rsp_over_mask         = rsp_ff.over_mask;
   assign rsp_under_mask        = rsp_ff.under_mask;

   held_item_not_dropped: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(req_ff))
      else $error("buffered item lost while result side stalled");

   masks_only_at_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.window_done |-> rsp_ff.over_mask == '0 && rsp_ff.under_mask == '0)
      else $error("limit mask set outside window close");

   close_sets_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.window_done |-> rsp_ff.sums_ready)
      else $error("window close without ready flag");

endmodule

`default_nettype wire
